@@ hw/rtl/parabolic_subpixel_disparity_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the subpixel disparity refinement block
// Shorthand for clocked implications that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_SUBPIXEL_DISPARITY_MACROS_SVH
`define PARABOLIC_SUBPIXEL_DISPARITY_MACROS_SVH

// Same-cycle implication.
`define PSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, register codes and types of the disparity refinement.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int COST_WIDTH = 16;
    localparam int DISP_WIDTH = 10;
    localparam int OUT_WIDTH  = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REFINE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISPARITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISPARITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_COST  = 2'd3;

    localparam logic               RST_REFINE_ENABLE = 1'b1;
    localparam logic signed [9:0]  RST_MIN_DISPARITY = 10'sd0;
    localparam logic signed [10:0] RST_MAX_DISPARITY = 11'sd64;
    localparam logic [15:0]        RST_INVALID_COST  = 16'hFFFF;

    typedef struct packed {
        logic               refine_enable;
        logic signed [9:0]  min_disparity;
        logic signed [10:0] max_disparity;
        logic [15:0]        invalid_cost;
    } t_cfg;

endpackage

@@ hw/rtl/psd_front.sv @@
// ----------------------------------------------------------------------------
// psd_front
// Two pipeline stages: qualification of the pixel and costs, then the
// curvature, the divider operands and the saturation check.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int DW = psd_pkg::DISP_WIDTH,
    parameter int CW = psd_pkg::COST_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psd_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_disparity,
    input  logic                 i_pixel_valid,
    input  logic [CW-1:0]        i_cost_prev,
    input  logic [CW-1:0]        i_cost_mid,
    input  logic [CW-1:0]        i_cost_next,
    input  logic [2:0]           i_costs_present,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_disparity,
    output logic                 o_take,
    output logic                 o_neg,
    output logic                 o_sat,
    output logic [CW+1:0]        o_den,
    output logic [CW+1:0]        o_rem
);

    localparam int WI   = ((DW > 11) ? DW : 11) + 2;
    localparam int CMPW = (CW > 16) ? CW : 16;
    localparam logic signed [WI-1:0] ONE_W  = WI'(1);
    localparam logic signed [WI-1:0] ZERO_W = '0;

    logic                 w_ready1;
    logic                 w_ready2;

    logic                 r_v1;
    logic signed [DW-1:0] r_d1;
    logic                 r_ok1;
    logic                 r_neg1;
    logic [CW-1:0]        r_mag1;
    logic [CW:0]          r_sum1;
    logic [CW:0]          r_mid2x1;

    logic signed [WI-1:0] w_idx;
    logic signed [WI-1:0] w_num;
    logic [CMPW-1:0]      w_inv;
    logic                 n_ok;
    logic                 n_neg;
    logic [CW-1:0]        n_mag;

    logic signed [CW+1:0] w_curv;
    logic                 w_pos;
    logic [CW+1:0]        w_den;

    logic                 r_v2;
    logic signed [DW-1:0] r_d2;
    logic                 r_take2;
    logic                 r_neg2;
    logic                 r_sat2;
    logic [CW+1:0]        r_den2;
    logic [CW+1:0]        r_rem2;

    assign w_ready2 = !r_v2 || i_ready;
    assign w_ready1 = !r_v1 || w_ready2;
    assign o_ready  = w_ready1;

    always_comb begin
        w_idx = WI'(i_disparity) - WI'(i_cfg.min_disparity);
        w_num = WI'(i_cfg.max_disparity) - WI'(i_cfg.min_disparity);
        w_inv = CMPW'(i_cfg.invalid_cost);
        n_ok  = i_cfg.refine_enable && i_pixel_valid
              && (w_idx > ZERO_W) && (w_idx < (w_num - ONE_W))
              && (i_costs_present == 3'b111)
              && (CMPW'(i_cost_prev) < w_inv)
              && (CMPW'(i_cost_mid) < w_inv)
              && (CMPW'(i_cost_next) < w_inv);
        n_neg = i_cost_prev < i_cost_next;
        n_mag = n_neg ? (i_cost_next - i_cost_prev) : (i_cost_prev - i_cost_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ready1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1) begin
            r_d1     <= i_disparity;
            r_ok1    <= n_ok;
            r_neg1   <= n_neg;
            r_mag1   <= n_mag;
            r_sum1   <= (CW+1)'(i_cost_prev) + (CW+1)'(i_cost_next);
            r_mid2x1 <= {i_cost_mid, 1'b0};
        end
    end

    // Curvature is c0 + c2 - 2*c1; the divisor is twice that.
    always_comb begin
        w_curv = $signed({1'b0, r_sum1}) - $signed({1'b0, r_mid2x1});
        w_pos  = !w_curv[CW+1] && (|w_curv);
        w_den  = {w_curv[CW:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2) begin
            r_d2    <= r_d1;
            r_take2 <= r_ok1 && w_pos;
            r_neg2  <= r_neg1;
            r_sat2  <= (CW+2)'(r_mag1) >= w_den;
            r_den2  <= w_den;
            r_rem2  <= (CW+2)'(r_mag1);
        end
    end

    assign o_valid     = r_v2;
    assign o_disparity = r_d2;
    assign o_take      = r_take2;
    assign o_neg       = r_neg2;
    assign o_sat       = r_sat2;
    assign o_den       = r_den2;
    assign o_rem       = r_rem2;

endmodule

@@ hw/rtl/psd_div_stage.sv @@
// ----------------------------------------------------------------------------
// psd_div_stage
// One restoring-division step: produces one quotient bit and carries the
// rest of the pixel along.
// ----------------------------------------------------------------------------
module psd_div_stage #(
    parameter int DW = psd_pkg::DISP_WIDTH,
    parameter int CW = psd_pkg::COST_WIDTH,
    parameter int FB = psd_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_disparity,
    input  logic                 i_take,
    input  logic                 i_neg,
    input  logic                 i_sat,
    input  logic [CW+1:0]        i_den,
    input  logic [CW+1:0]        i_rem,
    input  logic [FB-1:0]        i_quot,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_disparity,
    output logic                 o_take,
    output logic                 o_neg,
    output logic                 o_sat,
    output logic [CW+1:0]        o_den,
    output logic [CW+1:0]        o_rem,
    output logic [FB-1:0]        o_quot
);

    logic [CW+2:0] w_rem2x;
    logic [CW+2:0] w_den_x;
    logic          w_ge;
    logic [CW+1:0] n_rem;

    logic                 r_valid;
    logic signed [DW-1:0] r_disparity;
    logic                 r_take;
    logic                 r_neg;
    logic                 r_sat;
    logic [CW+1:0]        r_den;
    logic [CW+1:0]        r_rem;
    logic [FB-1:0]        r_quot;

    // The remainder stays below the divisor, so both branches fit CW+2 bits.
    always_comb begin
        w_rem2x = {i_rem, 1'b0};
        w_den_x = {1'b0, i_den};
        w_ge    = w_rem2x >= w_den_x;
        n_rem   = w_ge ? (CW+2)'(w_rem2x - w_den_x) : (CW+2)'(w_rem2x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_disparity <= i_disparity;
            r_take      <= i_take;
            r_neg       <= i_neg;
            r_sat       <= i_sat;
            r_den       <= i_den;
            r_rem       <= n_rem;
            r_quot      <= FB'({i_quot, w_ge});
        end
    end

    assign o_valid     = r_valid;
    assign o_disparity = r_disparity;
    assign o_take      = r_take;
    assign o_neg       = r_neg;
    assign o_sat       = r_sat;
    assign o_den       = r_den;
    assign o_rem       = r_rem;
    assign o_quot      = r_quot;

endmodule

@@ hw/rtl/parabolic_subpixel_disparity.sv @@
// A word accepted on the input passes the front-end registers, one restoring-divider
// stage per quotient bit and the output register in turn before it appears on o_valid.
// Throughput: one word per cycle while the output is not stalled.
// A held output only blocks the input once every stage in front of it is full.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// refinement on, range 0 to 64, invalid cost threshold 65535.
// ----------------------------------------------------------------------------
// parabolic_subpixel_disparity
// Parabola-fit subpixel refinement of integer stereo disparities, one pixel per clock
// unless the output stalls, result in signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
`include "parabolic_subpixel_disparity_macros.svh"

module parabolic_subpixel_disparity #(
    parameter int FRAC_BITS  = psd_pkg::FRAC_BITS,
    parameter int COST_WIDTH = psd_pkg::COST_WIDTH,
    parameter int DISP_WIDTH = psd_pkg::DISP_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [DISP_WIDTH-1:0]   i_disparity,
    input  logic                           i_pixel_valid,
    input  logic [COST_WIDTH-1:0]          i_cost_prev,
    input  logic [COST_WIDTH-1:0]          i_cost_mid,
    input  logic [COST_WIDTH-1:0]          i_cost_next,
    input  logic [2:0]                     i_costs_present,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [psd_pkg::OUT_WIDTH-1:0] o_refined_disparity,
    output logic                           o_was_refined
);

    localparam int FB   = FRAC_BITS;
    localparam int CW   = COST_WIDTH;
    localparam int DW   = DISP_WIDTH;
    localparam int OW   = psd_pkg::OUT_WIDTH;
    // Wide enough for the scaled disparity plus a full-scale offset, and
    // never narrower than the output so the final slice is a plain wrap.
    localparam int RW   = ((DW + FB + 2) > OW) ? (DW + FB + 2) : OW;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while idle;
    // the block does not enforce it and reads them without shadow copies.
    // ------------------------------------------------------------------
    psd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refine_enable <= psd_pkg::RST_REFINE_ENABLE;
            r_cfg.min_disparity <= psd_pkg::RST_MIN_DISPARITY;
            r_cfg.max_disparity <= psd_pkg::RST_MAX_DISPARITY;
            r_cfg.invalid_cost  <= psd_pkg::RST_INVALID_COST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psd_pkg::CFG_REFINE_ENABLE: begin
                    r_cfg.refine_enable <= i_cfg_data[0];
                end
                psd_pkg::CFG_MIN_DISPARITY: begin
                    r_cfg.min_disparity <= i_cfg_data[9:0];
                end
                psd_pkg::CFG_MAX_DISPARITY: begin
                    r_cfg.max_disparity <= i_cfg_data[10:0];
                end
                psd_pkg::CFG_INVALID_COST: begin
                    r_cfg.invalid_cost <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline links. Index k is the output of the front end (k = 0) or
    // of divider step k (k = 1..FB). w_take[k] says that whatever reads
    // link k loads at this edge; a stage loads when it is empty or when
    // its own consumer loads, so bubbles are squeezed out under a stall.
    // ------------------------------------------------------------------
    logic                 w_valid [0:FB];
    logic                 w_take  [0:FB];
    logic signed [DW-1:0] w_disp  [0:FB];
    logic                 w_refok [0:FB];
    logic                 w_neg   [0:FB];
    logic                 w_sat   [0:FB];
    logic [CW+1:0]        w_den   [0:FB];
    logic [CW+1:0]        w_rem   [0:FB];
    logic [FB-1:0]        w_quot  [0:FB];

    logic                 w_front_ready;
    logic                 w_out_ready;

    assign w_out_ready = !o_valid || !i_stall;
    assign o_stall     = !w_front_ready;

    always_comb begin
        w_take[FB] = w_out_ready;
        for (int k = FB - 1; k >= 0; k--) begin
            w_take[k] = !w_valid[k+1] || w_take[k+1];
        end
    end

    // Front end: range and cost qualification, curvature, divider operands.
    psd_front #(
        .DW (DW),
        .CW (CW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .i_disparity     (i_disparity),
        .i_pixel_valid   (i_pixel_valid),
        .i_cost_prev     (i_cost_prev),
        .i_cost_mid      (i_cost_mid),
        .i_cost_next     (i_cost_next),
        .i_costs_present (i_costs_present),
        .i_ready         (w_take[0]),
        .o_ready         (w_front_ready),
        .o_valid         (w_valid[0]),
        .o_disparity     (w_disp[0]),
        .o_take          (w_refok[0]),
        .o_neg           (w_neg[0]),
        .o_sat           (w_sat[0]),
        .o_den           (w_den[0]),
        .o_rem           (w_rem[0])
    );

    // The quotient is built up from nothing; the front end leaves the
    // remainder below the divisor unless the offset saturates.
    assign w_quot[0] = '0;

    // Divider: one quotient bit per stage, most significant first.
    for (genvar g = 0; g < FB; g++) begin : g_div
        psd_div_stage #(
            .DW (DW),
            .CW (CW),
            .FB (FB)
        ) u_div (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_take[g]),
            .i_valid     (w_valid[g]),
            .i_disparity (w_disp[g]),
            .i_take      (w_refok[g]),
            .i_neg       (w_neg[g]),
            .i_sat       (w_sat[g]),
            .i_den       (w_den[g]),
            .i_rem       (w_rem[g]),
            .i_quot      (w_quot[g]),
            .o_valid     (w_valid[g+1]),
            .o_disparity (w_disp[g+1]),
            .o_take      (w_refok[g+1]),
            .o_neg       (w_neg[g+1]),
            .o_sat       (w_sat[g+1]),
            .o_den       (w_den[g+1]),
            .o_rem       (w_rem[g+1]),
            .o_quot      (w_quot[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage. A saturated offset is exactly one pixel; otherwise the
    // quotient is below one. The sign of c0 - c2 is applied afterwards,
    // which gives truncation toward zero. The sum wraps to the port width.
    // ------------------------------------------------------------------
    logic [FB:0]          w_qmag;
    logic signed [RW-1:0] w_base;
    logic signed [RW-1:0] w_off;
    logic signed [RW-1:0] n_result;

    logic                 r_out_valid;
    logic signed [OW-1:0] r_result;
    logic                 r_refined;

    always_comb begin
        w_qmag   = w_sat[FB] ? ((FB+1)'(1) << FB) : {1'b0, w_quot[FB]};
        w_base   = RW'(w_disp[FB]) <<< FB;
        w_off    = $signed(RW'(w_qmag));
        if (w_neg[FB]) begin
            w_off = -w_off;
        end
        n_result = w_refok[FB] ? (w_base + w_off) : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[FB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_result  <= n_result[OW-1:0];
            r_refined <= w_refok[FB];
        end
    end

    assign o_valid             = r_out_valid;
    assign o_refined_disparity = r_result;
    assign o_was_refined       = r_refined;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A passed-through disparity is an integer: no fraction bits set.
    `PSD_ASSERT_IMPL(a_pass_integer, i_clk, i_rst_n, o_valid && !o_was_refined, o_refined_disparity[FB-1:0] == '0, "pass-through result has fraction bits")
    // With the output register empty the whole pipeline can move.
    `PSD_ASSERT_IMPL(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled while output register empty")
    // A taken result with nothing behind it leaves the output empty.
    `PSD_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, o_valid && !i_stall && !w_valid[FB], !o_valid, "output valid without a pending word")

endmodule
